FILE: sv/assert_macros.svh
// Assertion macros for the checker file of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/spe_pkg.sv
// Package of the spring particle Euler step: fixed point constants, reset values,
// register indexes, sequencer states and small saturation helpers. No dependencies.
package spe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MASS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y    = 3'd7;

    // Iteration counts of the bit-serial units.
    localparam int MUL_STEPS  = 33;
    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 32;

    // Reset values are given in Q16.16 and rescaled to FRAC_BITS.
    localparam longint QSCALE = longint'(1) << FRAC_BITS;
    localparam logic [30:0] RST_REST_LEN  = 31'(longint'(26214) * QSCALE / 65536);
    localparam logic [30:0] RST_STIFF     = 31'(longint'(327680) * QSCALE / 65536);
    localparam logic [15:0] RST_DAMP      = 16'(longint'(328) * QSCALE / 65536);
    localparam logic [30:0] RST_INV_MASS  = 31'(longint'(6553600) * QSCALE / 65536);
    localparam logic [31:0] RST_GRAVITY_Y = 32'(longint'(-642908) * QSCALE / 65536);
    localparam logic [31:0] RST_POS_X     = 32'(longint'(32768) * QSCALE / 65536);

    localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
    localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQR,
        ST_SQRT,
        ST_TEN,
        ST_FMUL,
        ST_FDIV,
        ST_DAMP,
        ST_ACCM,
        ST_VDT,
        ST_PDT,
        ST_DONE
    } t_state;

    // Clamp to the signed 32-bit range; bit 32 of the result flags a clamp.
    function automatic logic [32:0] f_sat(input logic signed [67:0] x);
        logic [32:0] res;
        if (x > SAT_HI) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (x < SAT_LO) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, x[31:0]};
        end
        return res;
    endfunction

    // Sign and magnitude to two's complement.
    function automatic logic signed [67:0] f_sm(input logic neg, input logic [65:0] m);
        logic signed [67:0] v;
        v = $signed({2'b00, m});
        return neg ? -v : v;
    endfunction

    function automatic logic [31:0] f_abs32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

endpackage

FILE: sv/spring_particle_euler_step.sv
// Top level of the spring particle Euler step: sequencer with bit-serial
// multiplier, square root and divider. Depends on spe_pkg.
//
// Usage: every request on the input channel (i_valid / o_ready) is one time
// tick carrying the step size dt in i_step_size. The block keeps the position
// and velocity of one particle hung from an anchor by a spring and answers each
// tick with one result on the output channel (o_valid / i_ready): the new
// position, the new velocity, a zero-length flag and a saturation flag.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write them only while no tick is in flight; the block does not enforce it.
// Timing: all arithmetic runs through one shift-add multiplier that retires
// one multiplier bit per cycle, a restoring square root and a restoring
// divider. A tick takes 19 products, one root and three quotients; when the
// spring length is zero the force phase is skipped. The next request is
// taken only once the sequencer has moved its result on and is idle again.
// The block works on one tick at a time; the result register lets the next
// tick start while a result still waits. If the receiver stalls, a finished
// tick waits in its final state until the result register is free.
// Reset (synchronous, active low) restores the register defaults, puts the
// particle at x = 0.5 with zero velocity and drops any pending result.
module spring_particle_euler_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [15:0]                         i_step_size,
    input  logic                                i_cfg_we,
    input  logic [spe_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [spe_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [31:0]                  o_out_pos_x,
    output logic signed [31:0]                  o_out_pos_y,
    output logic signed [31:0]                  o_out_pos_z,
    output logic signed [31:0]                  o_out_vel_x,
    output logic signed [31:0]                  o_out_vel_y,
    output logic signed [31:0]                  o_out_vel_z,
    output logic                                o_zero_length,
    output logic                                o_saturated
);

    // Configuration registers.
    logic signed [31:0] r_anchor [3];
    logic [30:0]        r_rest;
    logic [30:0]        r_stiff;
    logic [15:0]        r_damp;
    logic [30:0]        r_inv_mass;
    logic signed [31:0] r_grav;

    // Particle state and per-tick working registers.
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_np  [3];
    logic signed [31:0] r_nv  [3];
    logic signed [31:0] r_fs  [3];
    logic signed [31:0] r_ten;
    logic signed [31:0] r_tmp;
    logic [15:0]        r_dt;
    logic               r_zl;
    logic               r_sat;

    // Sequencer.
    spe_pkg::t_state r_state, n_state;
    logic [1:0]      r_axis, n_axis;
    logic [5:0]      r_cnt;

    // Serial arithmetic: multiplier shift register, partial product, root and divider unit.
    logic [32:0] r_mb;
    logic [65:0] r_mp;
    logic [65:0] r_sum;
    logic [65:0] r_sq;
    logic [33:0] r_rem;
    logic [32:0] r_root;

    // Result register.
    logic               r_ovalid;
    logic signed [31:0] r_opos [3];
    logic signed [31:0] r_ovel [3];
    logic               r_ozl;
    logic               r_osat;

    // Combinational signals.
    logic signed [32:0] d_full [3];
    logic [32:0]        dmag   [3];
    logic [2:0]         dneg;
    logic signed [31:0] vel_ax, pos_ax;
    logic signed [33:0] ldiff;
    logic [32:0]        lmag;
    logic               ten_neg;
    logic [32:0]        ma, mb_load;
    logic [33:0]        m_sum;
    logic [65:0]        m_next, sh_p;
    logic [35:0]        sq_rem, sq_trial;
    logic               sq_ge;
    logic [33:0]        sq_rem_n;
    logic [32:0]        sq_root_n;
    logic [33:0]        dv_t;
    logic               dv_ge;
    logic [33:0]        dv_rem_n;
    logic [31:0]        q_n;
    logic               last, ld, done_fire;
    logic signed [67:0] x_pre;
    logic [32:0]        sat_res;

    // Anchor to particle differences, one subtractor per axis.
    for (genvar a = 0; a < 3; a++) begin : g_diff
        assign d_full[a] = 33'(r_anchor[a]) - 33'(r_pos[a]);
        assign dneg[a]   = d_full[a][32];
        assign dmag[a]   = dneg[a] ? 33'(-d_full[a]) : 33'(d_full[a]);
    end

    assign vel_ax  = r_vel[r_axis];
    assign pos_ax  = r_pos[r_axis];
    assign ldiff   = $signed({1'b0, r_root}) - $signed({3'b000, r_rest});
    assign lmag    = ldiff[33] ? 33'(-ldiff) : ldiff[32:0];
    assign ten_neg = ldiff[33];

    // Multiplicand is held steady by the registers it comes from.
    always_comb begin
        unique case (r_state)
            spe_pkg::ST_SQR:  ma = dmag[r_axis];
            spe_pkg::ST_TEN:  ma = lmag;
            spe_pkg::ST_FMUL: ma = {1'b0, spe_pkg::f_abs32(r_ten)};
            spe_pkg::ST_DAMP,
            spe_pkg::ST_PDT:  ma = {1'b0, spe_pkg::f_abs32(vel_ax)};
            spe_pkg::ST_ACCM,
            spe_pkg::ST_VDT:  ma = {1'b0, spe_pkg::f_abs32(r_tmp)};
            default:          ma = '0;
        endcase
    end

    // Multiplier loaded into the shift register when an operation starts.
    always_comb begin
        unique case (n_state)
            spe_pkg::ST_SQR,
            spe_pkg::ST_FMUL: mb_load = dmag[n_axis];
            spe_pkg::ST_TEN:  mb_load = {2'b00, r_stiff};
            spe_pkg::ST_DAMP: mb_load = {17'd0, r_damp};
            spe_pkg::ST_ACCM: mb_load = {2'b00, r_inv_mass};
            spe_pkg::ST_VDT,
            spe_pkg::ST_PDT:  mb_load = {17'd0, r_dt};
            default:          mb_load = '0;
        endcase
    end

    // One multiplier bit per cycle: add into the upper half, shift right.
    assign m_sum  = {1'b0, r_mp[65:33]} + {1'b0, (r_mb[0] ? ma : 33'd0)};
    assign m_next = {m_sum, r_mp[32:1]};
    assign sh_p   = m_next >> spe_pkg::FRAC_BITS;

    // One root bit per cycle from the next pair of radicand bits.
    assign sq_rem    = {r_rem, r_sq[65:64]};
    assign sq_trial  = {1'b0, r_root, 2'b01};
    assign sq_ge     = (sq_rem >= sq_trial);
    assign sq_rem_n  = sq_ge ? 34'(sq_rem - sq_trial) : sq_rem[33:0];
    assign sq_root_n = {r_root[31:0], sq_ge};

    // One quotient bit per cycle; the divisor is the spring length.
    assign dv_t     = {r_rem[32:0], r_mp[31]};
    assign dv_ge    = (dv_t >= {1'b0, r_root});
    assign dv_rem_n = dv_ge ? 34'(dv_t - {1'b0, r_root}) : dv_t;
    assign q_n      = {r_mp[30:0], dv_ge};

    assign last = (r_state == spe_pkg::ST_FDIV) ? (r_cnt == 6'(spe_pkg::DIV_STEPS - 1))
                : (r_state == spe_pkg::ST_SQRT) ? (r_cnt == 6'(spe_pkg::SQRT_STEPS - 1))
                : (r_cnt == 6'(spe_pkg::MUL_STEPS - 1));

    // Value of the finishing operation before clamping.
    always_comb begin
        unique case (r_state)
            spe_pkg::ST_TEN:  x_pre = spe_pkg::f_sm(ten_neg, sh_p);
            spe_pkg::ST_FDIV: x_pre = spe_pkg::f_sm(r_ten[31] ^ dneg[r_axis], {34'd0, q_n});
            spe_pkg::ST_DAMP: x_pre = 68'(r_fs[r_axis]) - spe_pkg::f_sm(vel_ax[31], sh_p);
            spe_pkg::ST_ACCM: x_pre = spe_pkg::f_sm(r_tmp[31], sh_p)
                                    + ((r_axis == 2'd1) ? 68'(r_grav) : 68'sd0);
            spe_pkg::ST_VDT:  x_pre = 68'(vel_ax) + spe_pkg::f_sm(r_tmp[31], sh_p);
            spe_pkg::ST_PDT:  x_pre = 68'(pos_ax) + spe_pkg::f_sm(vel_ax[31], sh_p);
            default:          x_pre = 68'sd0;
        endcase
    end
    assign sat_res = spe_pkg::f_sat(x_pre);

    // Next state. Axes are walked in order x, y, z inside each phase.
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        unique case (r_state)
            spe_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = spe_pkg::ST_SQR;
                    n_axis  = 2'd0;
                end
            end
            spe_pkg::ST_SQR: begin
                if (last) begin
                    if (r_axis == 2'd2) begin
                        n_state = spe_pkg::ST_SQRT;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end
            end
            spe_pkg::ST_SQRT: begin
                if (last) begin
                    n_axis  = 2'd0;
                    n_state = (sq_root_n == 33'd0) ? spe_pkg::ST_DAMP : spe_pkg::ST_TEN;
                end
            end
            spe_pkg::ST_TEN: begin
                if (last) begin
                    n_state = spe_pkg::ST_FMUL;
                end
            end
            spe_pkg::ST_FMUL: begin
                if (last) begin
                    n_state = spe_pkg::ST_FDIV;
                end
            end
            spe_pkg::ST_FDIV: begin
                if (last) begin
                    if (r_axis == 2'd2) begin
                        n_state = spe_pkg::ST_DAMP;
                        n_axis  = 2'd0;
                    end else begin
                        n_state = spe_pkg::ST_FMUL;
                        n_axis  = r_axis + 2'd1;
                    end
                end
            end
            spe_pkg::ST_DAMP: begin
                if (last) begin
                    n_state = spe_pkg::ST_ACCM;
                end
            end
            spe_pkg::ST_ACCM: begin
                if (last) begin
                    n_state = spe_pkg::ST_VDT;
                end
            end
            spe_pkg::ST_VDT: begin
                if (last) begin
                    n_state = spe_pkg::ST_PDT;
                end
            end
            spe_pkg::ST_PDT: begin
                if (last) begin
                    if (r_axis == 2'd2) begin
                        n_state = spe_pkg::ST_DONE;
                    end else begin
                        n_state = spe_pkg::ST_DAMP;
                        n_axis  = r_axis + 2'd1;
                    end
                end
            end
            spe_pkg::ST_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_state = spe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spe_pkg::ST_IDLE;
            end
        endcase
    end

    assign ld = ((r_state == spe_pkg::ST_IDLE) && i_valid)
             || (last && (r_state != spe_pkg::ST_IDLE) && (r_state != spe_pkg::ST_DONE));
    assign done_fire = (r_state == spe_pkg::ST_DONE) && (!r_ovalid || i_ready);

    // Control state, configuration and particle state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spe_pkg::ST_IDLE;
            r_axis     <= 2'd0;
            r_ovalid   <= 1'b0;
            r_anchor   <= '{default: 32'sd0};
            r_rest     <= spe_pkg::RST_REST_LEN;
            r_stiff    <= spe_pkg::RST_STIFF;
            r_damp     <= spe_pkg::RST_DAMP;
            r_inv_mass <= spe_pkg::RST_INV_MASS;
            r_grav     <= $signed(spe_pkg::RST_GRAVITY_Y);
            r_pos[0]   <= $signed(spe_pkg::RST_POS_X);
            r_pos[1]   <= 32'sd0;
            r_pos[2]   <= 32'sd0;
            r_vel      <= '{default: 32'sd0};
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    spe_pkg::CFG_ANCHOR_X:     r_anchor[0] <= $signed(i_cfg_data);
                    spe_pkg::CFG_ANCHOR_Y:     r_anchor[1] <= $signed(i_cfg_data);
                    spe_pkg::CFG_ANCHOR_Z:     r_anchor[2] <= $signed(i_cfg_data);
                    spe_pkg::CFG_REST_LENGTH:  r_rest      <= i_cfg_data[30:0];
                    spe_pkg::CFG_STIFFNESS:    r_stiff     <= i_cfg_data[30:0];
                    spe_pkg::CFG_DAMPING:      r_damp      <= i_cfg_data[15:0];
                    spe_pkg::CFG_INVERSE_MASS: r_inv_mass  <= i_cfg_data[30:0];
                    spe_pkg::CFG_GRAVITY_Y:    r_grav      <= $signed(i_cfg_data);
                endcase
            end
            if (done_fire) begin
                r_pos    <= r_np;
                r_vel    <= r_nv;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath of the serial units and the per-tick working registers.
    always_ff @(posedge i_clk) begin
        if (r_state == spe_pkg::ST_IDLE && i_valid) begin
            r_dt  <= i_step_size;
            r_sat <= 1'b0;
            r_sum <= '0;
        end else if (last && r_state != spe_pkg::ST_IDLE && r_state != spe_pkg::ST_SQR
                && r_state != spe_pkg::ST_FMUL && r_state != spe_pkg::ST_SQRT
                && r_state != spe_pkg::ST_DONE) begin
            r_sat <= r_sat | sat_res[32];
        end

        if (ld) begin
            r_cnt <= 6'd0;
            r_mb  <= mb_load;
            r_mp  <= (n_state == spe_pkg::ST_FDIV) ? m_next : 66'd0;
        end else begin
            r_cnt <= r_cnt + 6'd1;
            r_mb  <= {1'b0, r_mb[32:1]};
            if (r_state == spe_pkg::ST_FDIV) begin
                r_mp[31:0] <= q_n;
            end else begin
                r_mp <= m_next;
            end
        end

        unique case (r_state)
            spe_pkg::ST_SQR: begin
                if (last) begin
                    r_sum <= r_sum + m_next;
                    if (r_axis == 2'd2) begin
                        r_sq   <= r_sum + m_next;
                        r_rem  <= '0;
                        r_root <= '0;
                    end
                end
            end
            spe_pkg::ST_SQRT: begin
                r_sq   <= {r_sq[63:0], 2'b00};
                r_rem  <= sq_rem_n;
                r_root <= sq_root_n;
                if (last) begin
                    r_zl <= (sq_root_n == 33'd0);
                    r_fs <= '{default: 32'sd0};
                end
            end
            spe_pkg::ST_TEN: begin
                if (last) begin
                    r_ten <= $signed(sat_res[31:0]);
                end
            end
            spe_pkg::ST_FMUL: begin
                if (last) begin
                    // The quotient is known to fit 32 bits, so the high half
                    // of the product already lies below the divisor.
                    r_rem <= {2'b00, m_next[63:32]};
                end
            end
            spe_pkg::ST_FDIV: begin
                r_rem <= dv_rem_n;
                if (last) begin
                    r_fs[r_axis] <= $signed(sat_res[31:0]);
                end
            end
            spe_pkg::ST_DAMP,
            spe_pkg::ST_ACCM: begin
                if (last) begin
                    r_tmp <= $signed(sat_res[31:0]);
                end
            end
            spe_pkg::ST_VDT: begin
                if (last) begin
                    r_nv[r_axis] <= $signed(sat_res[31:0]);
                end
            end
            spe_pkg::ST_PDT: begin
                if (last) begin
                    r_np[r_axis] <= $signed(sat_res[31:0]);
                end
            end
            default: begin
            end
        endcase

        if (done_fire) begin
            r_opos <= r_np;
            r_ovel <= r_nv;
            r_ozl  <= r_zl;
            r_osat <= r_sat;
        end
    end

    assign o_ready       = (r_state == spe_pkg::ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_out_pos_x   = r_opos[0];
    assign o_out_pos_y   = r_opos[1];
    assign o_out_pos_z   = r_opos[2];
    assign o_out_vel_x   = r_ovel[0];
    assign o_out_vel_y   = r_ovel[1];
    assign o_out_vel_z   = r_ovel[2];
    assign o_zero_length = r_ozl;
    assign o_saturated   = r_osat;

endmodule

FILE: sv/spe_checker.sv
// Port-level checker for the spring particle Euler step, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module spe_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic signed [31:0]             o_out_pos_x,
    input logic signed [31:0]             o_out_pos_y,
    input logic signed [31:0]             o_out_pos_z,
    input logic signed [31:0]             o_out_vel_x,
    input logic signed [31:0]             o_out_vel_y,
    input logic signed [31:0]             o_out_vel_z,
    input logic                           o_zero_length,
    input logic                           o_saturated
);

    // A waiting result stays offered.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "result dropped")

    // A waiting result keeps its payload.
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_out_pos_x) && $stable(o_out_pos_y) && $stable(o_out_pos_z) && $stable(o_out_vel_x) && $stable(o_out_vel_y) && $stable(o_out_vel_z) && $stable(o_zero_length) && $stable(o_saturated), "result changed while stalled")

    // Only one tick is in flight: a taken request closes the input.
    `ASSERT_CLK(a_one_tick, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready, "second request taken")

    // A new result appears only as a tick finishes, never while idle.
    `ASSERT_CLK(a_result_from_tick, i_clk, i_rst_n, $rose(o_valid) |-> $past(!o_ready), "result without a tick")

    // Reset drops any pending result.
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "result survived reset")

endmodule

bind spring_particle_euler_step spe_checker u_spe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_pos_x   (o_out_pos_x),
    .o_out_pos_y   (o_out_pos_y),
    .o_out_pos_z   (o_out_pos_z),
    .o_out_vel_x   (o_out_vel_x),
    .o_out_vel_y   (o_out_vel_y),
    .o_out_vel_z   (o_out_vel_z),
    .o_zero_length (o_zero_length),
    .o_saturated   (o_saturated)
);
